>>> src/ppa_pkg.sv
// shared types and constants for the posterior proportion averager
package ppa_pkg;

  localparam int MAX_CATEGORIES_DEF = 64;
  localparam int KCFG_W   = 7;
  localparam int T_W      = 16;
  localparam int CAT_W    = 6;
  localparam int AU_W     = 33;
  localparam int P_W      = 25;
  localparam int SUM_W    = 39;
  localparam int TMP_W    = 31;
  localparam int PROD_W   = 58;
  localparam int LOG_W    = 32;
  localparam int DIFF_W   = 26;
  localparam int DIV_NUM_W = 58;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [P_W-1:0] ONE_Q24 = 25'h1000000;

  localparam logic REG_NUM_CATEGORIES = 1'b0;
  localparam logic REG_NUM_SAMPLES    = 1'b1;

  typedef struct packed {
    logic signed [47:0] lr;
    logic signed [40:0] d;
    logic [39:0]        pu;
    logic [39:0]        ps;
  } acc_t;

  typedef enum logic [4:0] {
    S_LOAD, S_PU_RD, S_PU_DIV, S_PU_WAIT, S_PS_RD, S_PS_MUL, S_PS_DIV, S_PS_WAIT,
    S_LPS, S_LPS_WAIT, S_LPU, S_LPU_WAIT, S_ACC, S_OUT_RD, S_M_DIV, S_M_WAIT, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PU_DIV, OP_PU_TAKE, OP_PS_MUL, OP_PS_DIV, OP_PS_TAKE,
    OP_LPS, OP_LPS_TAKE, OP_LPU, OP_LPU_TAKE, OP_ACC, OP_M_DIV, OP_M_TAKE, OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {M_PS, M_PU, M_D, M_LR} mfield_t;

  typedef struct packed {
    op_t     op;
    logic    first;
    mfield_t msel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic log_done;
    logic resp;
  } status_t;

endpackage

>>> src/ppa_if.sv
// word channel interfaces for input elements and category results
interface ppa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] alpha_u_sample;
  logic [31:0] alpha_s_sample;
  logic [15:0] count_u;
  logic [15:0] count_s;
  logic        response_bit;
  modport source (output valid, alpha_u_sample, alpha_s_sample, count_u, count_s,
                  response_bit, input ready);
  modport sink (input valid, alpha_u_sample, alpha_s_sample, count_u, count_s,
                response_bit, output ready);
endinterface

interface ppa_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         category_index;
  logic [24:0]        mean_ps;
  logic [24:0]        mean_pu;
  logic signed [25:0] mean_difference;
  logic signed [31:0] mean_log_ratio;
  logic               last_result;
  modport source (output valid, category_index, mean_ps, mean_pu, mean_difference,
                  mean_log_ratio, last_result, input ready);
  modport sink (input valid, category_index, mean_ps, mean_pu, mean_difference,
                mean_log_ratio, last_result, output ready);
endinterface

>>> src/ppa_ram.sv
// generic single-port-write ram with registered read
module ppa_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/ppa_div.sv
// restoring divider, one quotient bit per cycle
module ppa_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 39
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] q,
  output logic             done
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] qn_r, qn_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DEN_W:0]   sh, diff;
  logic             ge;

  always_comb begin
    sh   = {rem_r, qn_r[NUM_W-1]};
    ge   = sh >= {1'b0, den_r};
    diff = sh - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      qn_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      qn_nxt  = {qn_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign q    = qn_r;
  assign done = done_r;
endmodule

>>> src/ppa_log2.sv
// log2 of a q0.24 proportion into q8.24, one squaring step per cycle
module ppa_log2 (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ppa_pkg::P_W-1:0]  x,
  output logic signed [31:0]       y,
  output logic                     done
);
  logic              busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;
  logic [4:0]        cnt_r, cnt_nxt, p;
  logic [31:0]       m_r, m_nxt, sqh;
  logic [63:0]       sq;
  logic [7:0]        exp_r, exp_nxt;
  logic [23:0]       frac_r, frac_nxt;

  always_comb begin
    p = '0;
    for (int i = 0; i < ppa_pkg::P_W; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    sq  = m_r * m_r;
    sqh = sq[61:30];
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    m_nxt    = m_r;
    exp_nxt  = exp_r;
    frac_nxt = frac_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (start) begin
      zero_nxt = (x == '0);
      exp_nxt  = 8'(p) - 8'd24;
      m_nxt    = 32'(x) << (5'd30 - p);
      frac_nxt = '0;
      cnt_nxt  = 5'd24;
      busy_nxt = (x != '0);
      done_nxt = (x == '0);
    end else if (busy_r) begin
      if (sqh[31]) begin
        m_nxt    = {1'b0, sqh[31:1]};
        frac_nxt = {frac_r[22:0], 1'b1};
      end else begin
        m_nxt    = sqh;
        frac_nxt = {frac_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    m_r    <= m_nxt;
    exp_r  <= exp_nxt;
    frac_r <= frac_nxt;
    zero_r <= zero_nxt;
  end

  assign y    = zero_r ? 32'sh80000000 : {exp_r, frac_r};
  assign done = done_r;
endmodule

>>> src/ppa_datapath.sv
// stores, accumulators, divider and log2 unit driven by controller commands
module ppa_datapath #(
  parameter int MAX_CATEGORIES = ppa_pkg::MAX_CATEGORIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppa_pkg::cmd_t                 cmd,
  input  logic [$clog2(MAX_CATEGORIES)-1:0] addr,
  output ppa_pkg::status_t              status,
  input  logic [31:0]                   alpha_u_sample,
  input  logic [31:0]                   alpha_s_sample,
  input  logic [15:0]                   count_u,
  input  logic [15:0]                   count_s,
  input  logic                          response_bit,
  input  logic [ppa_pkg::T_W-1:0]       t_eff,
  output logic [24:0]                   mean_ps,
  output logic [24:0]                   mean_pu,
  output logic signed [25:0]            mean_difference,
  output logic signed [31:0]            mean_log_ratio
);
  localparam int ACC_W = $bits(ppa_pkg::acc_t);

  logic [ppa_pkg::AU_W-1:0]   au_in, as_in, au_rd, as_rd;
  logic                       resp_rd;
  logic [ppa_pkg::P_W-1:0]    pu_rd, pu_q, rem_w;
  ppa_pkg::acc_t              acc_rd, acc_old, acc_new;
  logic [MAX_CATEGORIES-1:0]  valid_r;
  logic [ppa_pkg::SUM_W-1:0]  sau_r, sas_r;
  logic [ppa_pkg::TMP_W-1:0]  tmp_r;
  logic [ppa_pkg::PROD_W-1:0] prod_r;
  logic [ppa_pkg::P_W-1:0]    ps_r;
  logic signed [31:0]         lps_r, lpu_r, log_y, lr32;
  logic signed [32:0]         lr33;
  logic signed [25:0]         d26;
  logic                       neg_r, neg_w;
  logic [24:0]                mps_r, mpu_r;
  logic signed [25:0]         md_r;
  logic signed [31:0]         mlr_r;
  logic                       div_start, div_done, log_start, log_done;
  logic [ppa_pkg::DIV_NUM_W-1:0] div_num, div_q, mag;
  logic [ppa_pkg::SUM_W-1:0]  div_den;
  logic [ppa_pkg::P_W-1:0]    log_x;
  logic [40:0]                d_abs;
  logic [47:0]                lr_abs;

  assign au_in = 33'(alpha_u_sample) + {1'b0, count_u, 16'b0};
  assign as_in = 33'(alpha_s_sample) + {1'b0, count_s, 16'b0};

  ppa_ram #(.W(ppa_pkg::AU_W), .D(MAX_CATEGORIES)) u_au_ram (
    .clk(clk), .we(cmd.op == ppa_pkg::OP_LOAD), .waddr(addr), .wdata(au_in),
    .raddr(addr), .rdata(au_rd));
  ppa_ram #(.W(ppa_pkg::AU_W), .D(MAX_CATEGORIES)) u_as_ram (
    .clk(clk), .we(cmd.op == ppa_pkg::OP_LOAD), .waddr(addr), .wdata(as_in),
    .raddr(addr), .rdata(as_rd));
  ppa_ram #(.W(1), .D(MAX_CATEGORIES)) u_resp_ram (
    .clk(clk), .we(cmd.op == ppa_pkg::OP_LOAD), .waddr(addr), .wdata(response_bit),
    .raddr(addr), .rdata(resp_rd));
  ppa_ram #(.W(ppa_pkg::P_W), .D(MAX_CATEGORIES)) u_pu_ram (
    .clk(clk), .we(cmd.op == ppa_pkg::OP_PU_TAKE), .waddr(addr), .wdata(pu_q),
    .raddr(addr), .rdata(pu_rd));
  ppa_ram #(.W(ACC_W), .D(MAX_CATEGORIES)) u_acc_ram (
    .clk(clk), .we(cmd.op == ppa_pkg::OP_ACC), .waddr(addr), .wdata(acc_new),
    .raddr(addr), .rdata(acc_rd));

  ppa_div #(.NUM_W(ppa_pkg::DIV_NUM_W), .DEN_W(ppa_pkg::SUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .q(div_q), .done(div_done));

  ppa_log2 u_log2 (
    .clk(clk), .rst_n(rst_n), .start(log_start), .x(log_x), .y(log_y), .done(log_done));

  always_comb begin
    acc_old = valid_r[addr] ? acc_rd : '0;
    pu_q    = (sau_r == '0) ? '0 : div_q[ppa_pkg::P_W-1:0];
    rem_w   = (tmp_r >= ppa_pkg::TMP_W'(ppa_pkg::ONE_Q24)) ? '0
              : ppa_pkg::ONE_Q24 - tmp_r[ppa_pkg::P_W-1:0];
    d_abs   = acc_old.d[40] ? 41'(-acc_old.d) : 41'(acc_old.d);
    lr_abs  = acc_old.lr[47] ? 48'(-acc_old.lr) : 48'(acc_old.lr);
    case (cmd.msel)
      ppa_pkg::M_PS: begin mag = 58'(acc_old.ps); neg_w = 1'b0; end
      ppa_pkg::M_PU: begin mag = 58'(acc_old.pu); neg_w = 1'b0; end
      ppa_pkg::M_D:  begin mag = 58'(d_abs);      neg_w = acc_old.d[40]; end
      default:       begin mag = 58'(lr_abs);     neg_w = acc_old.lr[47]; end
    endcase
    div_start = 1'b1;
    case (cmd.op)
      ppa_pkg::OP_PU_DIV: begin div_num = {1'b0, au_rd, 24'b0}; div_den = sau_r; end
      ppa_pkg::OP_PS_DIV: begin div_num = prod_r;              div_den = sas_r; end
      ppa_pkg::OP_M_DIV:  begin div_num = mag;          div_den = ppa_pkg::SUM_W'(t_eff); end
      default: begin
        div_num   = mag;
        div_den   = sau_r;
        div_start = 1'b0;
      end
    endcase
    log_start = (cmd.op == ppa_pkg::OP_LPS) || (cmd.op == ppa_pkg::OP_LPU);
    log_x     = (cmd.op == ppa_pkg::OP_LPS) ? ps_r : pu_rd;
    // non-responders contribute exactly zero difference and log ratio
    d26  = resp_rd ? (26'(ps_r) - 26'(pu_rd)) : '0;
    lr33 = 33'(lps_r) - 33'(lpu_r);
    if (!resp_rd) begin
      lr32 = '0;
    end else if (lr33 > 33'sh07fffffff) begin
      lr32 = 32'sh7fffffff;
    end else if (lr33 < -33'sh080000000) begin
      lr32 = 32'sh80000000;
    end else begin
      lr32 = lr33[31:0];
    end
    acc_new.ps = acc_old.ps + 40'(ps_r);
    acc_new.pu = acc_old.pu + 40'(pu_rd);
    acc_new.d  = acc_old.d + {{15{d26[25]}}, d26};
    acc_new.lr = acc_old.lr + {{16{lr32[31]}}, lr32};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.op == ppa_pkg::OP_CLEAR) begin
      valid_r <= '0;
    end else if (cmd.op == ppa_pkg::OP_ACC) begin
      valid_r[addr] <= 1'b1;
    end
    case (cmd.op)
      ppa_pkg::OP_LOAD: begin
        if (cmd.first) begin
          sau_r <= ppa_pkg::SUM_W'(au_in);
          sas_r <= response_bit ? ppa_pkg::SUM_W'(as_in) : '0;
        end else begin
          sau_r <= sau_r + ppa_pkg::SUM_W'(au_in);
          sas_r <= response_bit ? sas_r + ppa_pkg::SUM_W'(as_in) : sas_r;
        end
        if (cmd.first) begin
          tmp_r <= '0;
        end
      end
      ppa_pkg::OP_PU_TAKE: begin
        if (!resp_rd) begin
          tmp_r <= tmp_r + ppa_pkg::TMP_W'(pu_q);
        end
      end
      ppa_pkg::OP_PS_MUL: begin
        prod_r <= as_rd * rem_w;
        if (!resp_rd) begin
          ps_r <= pu_rd;
        end
      end
      ppa_pkg::OP_PS_TAKE: ps_r <= (sas_r == '0) ? '0 : div_q[ppa_pkg::P_W-1:0];
      ppa_pkg::OP_LPS_TAKE: lps_r <= log_y;
      ppa_pkg::OP_LPU_TAKE: lpu_r <= log_y;
      ppa_pkg::OP_M_DIV: neg_r <= neg_w;
      ppa_pkg::OP_M_TAKE: begin
        case (cmd.msel)
          ppa_pkg::M_PS: mps_r <= div_q[24:0];
          ppa_pkg::M_PU: mpu_r <= div_q[24:0];
          ppa_pkg::M_D:  md_r  <= neg_r ? -26'(div_q) : 26'(div_q);
          default:       mlr_r <= neg_r ? -32'(div_q) : 32'(div_q);
        endcase
      end
      default: begin
      end
    endcase
  end

  assign status.div_done = div_done;
  assign status.log_done = log_done;
  assign status.resp     = resp_rd;
  assign mean_ps         = mps_r;
  assign mean_pu         = mpu_r;
  assign mean_difference = md_r;
  assign mean_log_ratio  = mlr_r;
endmodule

>>> src/ppa_ctrl.sv
// sequencer: element loading, per-sample normalisation walk and result walk
module ppa_ctrl #(
  parameter int MAX_CATEGORIES = ppa_pkg::MAX_CATEGORIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_clear,
  input  logic [$clog2(MAX_CATEGORIES+1)-1:0]   k_eff,
  input  logic [ppa_pkg::T_W-1:0]               t_eff,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  input  ppa_pkg::status_t                      status,
  output ppa_pkg::cmd_t                         cmd,
  output logic [$clog2(MAX_CATEGORIES)-1:0]     addr,
  output logic                                  last_result
);
  localparam int AW = $clog2(MAX_CATEGORIES);

  ppa_pkg::state_t        state_r, state_nxt;
  logic [AW-1:0]          e_r, e_nxt, j_r, j_nxt, km1, km2;
  logic [ppa_pkg::T_W-1:0] s_r, s_nxt;
  ppa_pkg::mfield_t       f_r, f_nxt;
  logic [ppa_pkg::T_W:0]  s_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppa_pkg::S_LOAD;
      e_r     <= '0;
      j_r     <= '0;
      s_r     <= '0;
      f_r     <= ppa_pkg::M_PS;
    end else begin
      state_r <= state_nxt;
      e_r     <= e_nxt;
      j_r     <= j_nxt;
      s_r     <= s_nxt;
      f_r     <= f_nxt;
    end
  end

  always_comb begin
    km1   = AW'(k_eff - 1'b1);
    km2   = AW'(k_eff - 2'd2);
    s_inc = (ppa_pkg::T_W+1)'(s_r) + 1'b1;
    state_nxt = state_r;
    e_nxt = e_r;
    j_nxt = j_r;
    s_nxt = s_r;
    f_nxt = f_r;
    cmd.op    = ppa_pkg::OP_NONE;
    cmd.first = (e_r == '0);
    cmd.msel  = f_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ppa_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = ppa_pkg::OP_LOAD;
          if (e_r == km1) begin
            e_nxt = '0;
            j_nxt = '0;
            state_nxt = ppa_pkg::S_PU_RD;
          end else begin
            e_nxt = e_r + 1'b1;
          end
        end
      end
      ppa_pkg::S_PU_RD: state_nxt = ppa_pkg::S_PU_DIV;
      ppa_pkg::S_PU_DIV: begin
        cmd.op = ppa_pkg::OP_PU_DIV;
        state_nxt = ppa_pkg::S_PU_WAIT;
      end
      ppa_pkg::S_PU_WAIT: begin
        if (status.div_done) begin
          cmd.op = ppa_pkg::OP_PU_TAKE;
          if (j_r == km1) begin
            j_nxt = '0;
            state_nxt = ppa_pkg::S_PS_RD;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = ppa_pkg::S_PU_RD;
          end
        end
      end
      ppa_pkg::S_PS_RD: state_nxt = ppa_pkg::S_PS_MUL;
      ppa_pkg::S_PS_MUL: begin
        cmd.op = ppa_pkg::OP_PS_MUL;
        state_nxt = status.resp ? ppa_pkg::S_PS_DIV : ppa_pkg::S_ACC;
      end
      ppa_pkg::S_PS_DIV: begin
        cmd.op = ppa_pkg::OP_PS_DIV;
        state_nxt = ppa_pkg::S_PS_WAIT;
      end
      ppa_pkg::S_PS_WAIT: begin
        if (status.div_done) begin
          cmd.op = ppa_pkg::OP_PS_TAKE;
          state_nxt = ppa_pkg::S_LPS;
        end
      end
      ppa_pkg::S_LPS: begin
        cmd.op = ppa_pkg::OP_LPS;
        state_nxt = ppa_pkg::S_LPS_WAIT;
      end
      ppa_pkg::S_LPS_WAIT: begin
        if (status.log_done) begin
          cmd.op = ppa_pkg::OP_LPS_TAKE;
          state_nxt = ppa_pkg::S_LPU;
        end
      end
      ppa_pkg::S_LPU: begin
        cmd.op = ppa_pkg::OP_LPU;
        state_nxt = ppa_pkg::S_LPU_WAIT;
      end
      ppa_pkg::S_LPU_WAIT: begin
        if (status.log_done) begin
          cmd.op = ppa_pkg::OP_LPU_TAKE;
          state_nxt = ppa_pkg::S_ACC;
        end
      end
      ppa_pkg::S_ACC: begin
        cmd.op = ppa_pkg::OP_ACC;
        if (j_r == km1) begin
          j_nxt = '0;
          if (s_inc >= (ppa_pkg::T_W+1)'(t_eff)) begin
            state_nxt = ppa_pkg::S_OUT_RD;
          end else begin
            s_nxt = s_r + 1'b1;
            state_nxt = ppa_pkg::S_LOAD;
          end
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = ppa_pkg::S_PS_RD;
        end
      end
      ppa_pkg::S_OUT_RD: begin
        f_nxt = ppa_pkg::M_PS;
        state_nxt = ppa_pkg::S_M_DIV;
      end
      ppa_pkg::S_M_DIV: begin
        cmd.op = ppa_pkg::OP_M_DIV;
        state_nxt = ppa_pkg::S_M_WAIT;
      end
      ppa_pkg::S_M_WAIT: begin
        if (status.div_done) begin
          cmd.op = ppa_pkg::OP_M_TAKE;
          if (f_r == ppa_pkg::M_LR) begin
            state_nxt = ppa_pkg::S_OUT;
          end else begin
            f_nxt = ppa_pkg::mfield_t'(f_r + 2'd1);
            state_nxt = ppa_pkg::S_M_DIV;
          end
        end
      end
      ppa_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (j_r == km2) begin
            cmd.op = ppa_pkg::OP_CLEAR;
            j_nxt = '0;
            s_nxt = '0;
            state_nxt = ppa_pkg::S_LOAD;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = ppa_pkg::S_OUT_RD;
          end
        end
      end
      default: state_nxt = ppa_pkg::S_LOAD;
    endcase
    if (cfg_clear) begin
      cmd.op = ppa_pkg::OP_CLEAR;
      in_ready = 1'b0;
      state_nxt = ppa_pkg::S_LOAD;
      e_nxt = '0;
      j_nxt = '0;
      s_nxt = '0;
      f_nxt = ppa_pkg::M_PS;
    end
  end

  assign addr        = (state_r == ppa_pkg::S_LOAD) ? e_r : j_r;
  assign last_result = (j_r == km2);
endmodule

>>> src/posterior_proportion_averager.sv
// top level of the posterior proportion averager
// input: a word is taken when valid meets ready; the K-th word of a sample starts a walk
//   of the categories for pu, then one for ps in which only responders use the divider and log2
// results: each category word is computed on the shared 58-step divider and held through output stalls
// throughput: one word per cycle while loading, then the sample walk blocks input
// reset: rst_n synchronous, active low; clears the sequencer, counters and the
//   accumulator valid bits at once, so no clearing pass is needed
module posterior_proportion_averager #(
  parameter int MAX_CATEGORIES = ppa_pkg::MAX_CATEGORIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ppa_in_if.sink                             in_word,
  ppa_out_if.source                          out_word,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ppa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ppa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  localparam int AW = $clog2(MAX_CATEGORIES);
  localparam int KW = $clog2(MAX_CATEGORIES + 1);

  // configuration registers
  logic [ppa_pkg::KCFG_W-1:0] num_categories_r, num_categories_nxt;
  logic [ppa_pkg::T_W-1:0]    num_samples_r, num_samples_nxt;
  logic                       cfg_wr, cfg_clear;
  logic [KW-1:0]              k_eff;
  logic [ppa_pkg::T_W-1:0]    t_eff;
  ppa_pkg::cmd_t              cmd;
  ppa_pkg::status_t           status;
  logic [AW-1:0]              addr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register index comes from the word address bit; any write restarts the run
  always_comb begin
    num_categories_nxt = num_categories_r;
    num_samples_nxt    = num_samples_r;
    cfg_clear          = 1'b0;
    if (cfg_wr) begin
      cfg_clear = 1'b1;
      case (paddr[2])
        ppa_pkg::REG_NUM_CATEGORIES: num_categories_nxt = pwdata[ppa_pkg::KCFG_W-1:0];
        default:                     num_samples_nxt    = pwdata[ppa_pkg::T_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_categories_r <= ppa_pkg::KCFG_W'(2);
      num_samples_r    <= ppa_pkg::T_W'(1);
    end else begin
      num_categories_r <= num_categories_nxt;
      num_samples_r    <= num_samples_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      ppa_pkg::REG_NUM_CATEGORIES: prdata = ppa_pkg::CFG_DATA_W'(num_categories_r);
      default:                     prdata = ppa_pkg::CFG_DATA_W'(num_samples_r);
    endcase
  end

  // out-of-range category counts clamp to 2 .. MAX_CATEGORIES, zero samples acts as one
  always_comb begin
    if (num_categories_r < ppa_pkg::KCFG_W'(2)) begin
      k_eff = KW'(2);
    end else if (32'(num_categories_r) > MAX_CATEGORIES) begin
      k_eff = KW'(MAX_CATEGORIES);
    end else begin
      k_eff = KW'(num_categories_r);
    end
    t_eff = (num_samples_r == '0) ? ppa_pkg::T_W'(1) : num_samples_r;
  end

  ppa_ctrl #(.MAX_CATEGORIES(MAX_CATEGORIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_clear(cfg_clear), .k_eff(k_eff), .t_eff(t_eff),
    .in_valid(in_word.valid), .in_ready(in_word.ready),
    .out_valid(out_word.valid), .out_ready(out_word.ready),
    .status(status), .cmd(cmd), .addr(addr), .last_result(out_word.last_result));

  ppa_datapath #(.MAX_CATEGORIES(MAX_CATEGORIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .addr(addr), .status(status),
    .alpha_u_sample(in_word.alpha_u_sample), .alpha_s_sample(in_word.alpha_s_sample),
    .count_u(in_word.count_u), .count_s(in_word.count_s),
    .response_bit(in_word.response_bit), .t_eff(t_eff),
    .mean_ps(out_word.mean_ps), .mean_pu(out_word.mean_pu),
    .mean_difference(out_word.mean_difference), .mean_log_ratio(out_word.mean_log_ratio));

  // category number of the result word follows the walk index
  assign out_word.category_index = ppa_pkg::CAT_W'(addr);
endmodule

>>> src/ppa_checker.sv
// port-level checks for the posterior proportion averager, bound to the top level
module ppa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] category_index,
  input logic last_result,
  input logic pready
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is shown");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(category_index))
    else $error("stalled result word changed");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_result |=> !out_valid && in_ready)
    else $error("results continue after the last word");
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");
endmodule

bind posterior_proportion_averager ppa_checker u_ppa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_word.valid), .in_ready(in_word.ready),
  .out_valid(out_word.valid), .out_ready(out_word.ready),
  .category_index(out_word.category_index), .last_result(out_word.last_result),
  .pready(pready));

>>> sim/posterior_proportion_averager_tb.sv
// self-checking testbench for the posterior proportion averager
module posterior_proportion_averager_tb;

  localparam int  MAXK       = 64;
  localparam int  QUIET_MAX  = 80000;   // cycles with no handshake before giving up
  localparam int  ITEMS      = 350;
  localparam longint LOG_LO  = -64'sd2147483648;
  localparam longint LOG_HI  = 64'sd2147483647;
  localparam longint Q24_ONE = 64'sd16777216;

  typedef struct {
    logic [5:0]         cat;
    logic [24:0]        ps;
    logic [24:0]        pu;
    logic signed [25:0] diff;
    logic signed [31:0] lr;
    logic               last;
  } mean_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ppa_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ppa_pkg::CFG_DATA_W-1:0] pwdata, prdata;

  ppa_in_if  in_word_if ();
  ppa_out_if out_word_if ();

  posterior_proportion_averager u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word_if.sink),
    .out_word (out_word_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: stores, accumulators, counters and register copies
  // ---------------------------------------------------------------------------
  longint unsigned au_mem [MAXK];
  longint unsigned as_mem [MAXK];
  bit              resp_mem [MAXK];
  longint unsigned ps_sum [MAXK];
  longint unsigned pu_sum [MAXK];
  longint          diff_sum [MAXK];
  longint          lr_sum [MAXK];
  int unsigned     elem_cnt, samp_cnt;
  int unsigned     k_reg, t_reg;

  mean_word_t means_due [$];

  int errors, words_sent, means_seen, cfg_writes, quiet;

  function automatic int unsigned eff_k();
    if (k_reg < 2) return 2;
    if (k_reg > MAXK) return MAXK;
    return k_reg;
  endfunction

  function automatic int unsigned eff_t();
    return (t_reg == 0) ? 1 : t_reg;
  endfunction

  function automatic void clear_run();
    for (int j = 0; j < MAXK; j++) begin
      ps_sum[j] = 0; pu_sum[j] = 0; diff_sum[j] = 0; lr_sum[j] = 0;
    end
    elem_cnt = 0;
    samp_cnt = 0;
  endfunction

  // log2 of a q0.24 proportion, q8.24 result, by repeated squaring of the mantissa
  function automatic longint log2_q24(longint unsigned x);
    int p;
    longint unsigned m, frac;
    p = 0;
    frac = 0;
    if (x == 0) return LOG_LO;
    while (p < 40 && (x >> (p + 1)) != 0) p++;
    m = x << (30 - p);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - 24) * Q24_ONE + longint'(frac);
  endfunction

  // normalise one full sample and add it into the per-category sums
  function automatic void fold_sample(int unsigned k);
    longint unsigned pu [MAXK];
    longint unsigned sau, sas, nonresp, rem, ps;
    longint d, lr;
    sau = 0; sas = 0; nonresp = 0;
    for (int j = 0; j < k; j++) sau += au_mem[j];
    for (int j = 0; j < k; j++) begin
      pu[j] = (sau != 0) ? (au_mem[j] << 24) / sau : 0;
      if (resp_mem[j]) sas += as_mem[j];
      else nonresp += pu[j];
    end
    rem = (nonresp >= 64'd16777216) ? 0 : 64'd16777216 - nonresp;
    for (int j = 0; j < k; j++) begin
      d = 0;
      lr = 0;
      if (resp_mem[j]) begin
        ps = (sas != 0) ? (as_mem[j] * rem) / sas : 0;
        d = longint'(ps) - longint'(pu[j]);
        lr = log2_q24(ps) - log2_q24(pu[j]);
        if (lr < LOG_LO) lr = LOG_LO;
        if (lr > LOG_HI) lr = LOG_HI;
      end else begin
        ps = pu[j];
      end
      ps_sum[j] += ps;
      pu_sum[j] += pu[j];
      diff_sum[j] += d;
      lr_sum[j] += lr;
    end
  endfunction

  // one accepted element: store it, and on the last sample of a run queue the means
  function automatic void take_element(logic [31:0] au, logic [31:0] as_in,
                                       logic [15:0] cu, logic [15:0] cs, logic r);
    int unsigned k, t, e;
    mean_word_t w;
    k = eff_k();
    e = (elem_cnt >= k) ? 0 : elem_cnt;
    au_mem[e] = longint'(au) + (longint'(cu) << 16);
    as_mem[e] = longint'(as_in) + (longint'(cs) << 16);
    resp_mem[e] = r;
    elem_cnt = e + 1;
    if (elem_cnt < k) return;
    fold_sample(k);
    elem_cnt = 0;
    samp_cnt++;
    t = eff_t();
    if (samp_cnt < t) return;
    for (int j = 0; j + 1 < k; j++) begin
      w.cat  = j[5:0];
      w.ps   = 25'(ps_sum[j] / t);
      w.pu   = 25'(pu_sum[j] / t);
      w.diff = 26'(diff_sum[j] / longint'(t));   // signed division truncates toward zero
      w.lr   = 32'(lr_sum[j] / longint'(t));
      w.last = (j + 2 == k);
      means_due.push_back(w);
    end
    clear_run();
  endfunction

  // ---------------------------------------------------------------------------
  // result checking, receiver stall pattern and the quiet-cycle watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, means_seen);
    errors++;
  endtask

  int stall_mode, stall_left;

  always @(posedge clk) begin
    mean_word_t w;
    if (!rst_n) begin
      out_word_if.ready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_word_if.valid && out_word_if.ready) begin
        means_seen++;
        if (means_due.size() == 0) begin
          $display("mismatch: result for category %0d with none expected",
                   out_word_if.category_index);
          errors++;
        end else begin
          w = means_due.pop_front();
          if (out_word_if.category_index !== w.cat)
            report_mismatch("category_index", out_word_if.category_index, w.cat);
          if (out_word_if.mean_ps !== w.ps)
            report_mismatch("mean_ps", out_word_if.mean_ps, w.ps);
          if (out_word_if.mean_pu !== w.pu)
            report_mismatch("mean_pu", out_word_if.mean_pu, w.pu);
          if (out_word_if.mean_difference !== w.diff)
            report_mismatch("mean_difference", out_word_if.mean_difference, w.diff);
          if (out_word_if.mean_log_ratio !== w.lr)
            report_mismatch("mean_log_ratio", out_word_if.mean_log_ratio, w.lr);
          if (out_word_if.last_result !== w.last)
            report_mismatch("last_result", out_word_if.last_result, w.last);
        end
      end
      // stall pattern: free-running, coin-toss or mostly stalled, in stretches
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(30, 400);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_word_if.ready <= 1'b1;
        1: out_word_if.ready <= $urandom_range(0, 1);
        default: out_word_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_word_if.valid && in_word_if.ready) ||
        (out_word_if.valid && out_word_if.ready) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("timeout: no handshake for %0d cycles", QUIET_MAX);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------
  int burst_left;

  // send one element, with burst/gap shaping on the sender side
  task automatic send_element(logic [31:0] au, logic [31:0] as_in,
                              logic [15:0] cu, logic [15:0] cs, logic r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_word_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_word_if.valid          <= 1'b1;
    in_word_if.alpha_u_sample <= au;
    in_word_if.alpha_s_sample <= as_in;
    in_word_if.count_u        <= cu;
    in_word_if.count_s        <= cs;
    in_word_if.response_bit   <= r;
    @(posedge clk);
    while (!in_word_if.ready) @(posedge clk);
    take_element(au, as_in, cu, cs, r);
    words_sent++;
  endtask

  // biased field value: zero, all ones, a small value or anything
  function automatic logic [31:0] pick_field(int w);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = $urandom_range(0, 255);
      default: v = $urandom;
    endcase
    return v & ((w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1));
  endfunction

  task automatic send_random_element();
    send_element(pick_field(32), pick_field(32), 16'(pick_field(16)),
                 16'(pick_field(16)), $urandom_range(0, 1));
  endtask

  // stop sending, wait for every expected mean, then let a sample walk finish
  task automatic drain(int extra);
    in_word_if.valid <= 1'b0;
    @(posedge clk);
    while (means_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ppa_pkg::REG_NUM_CATEGORIES) k_reg = value & 32'h7F;
    else t_reg = value & 32'hFFFF;
    clear_run();
    cfg_writes++;
  endtask

  task automatic configure(logic [31:0] k, logic [31:0] t);
    drain(eff_k() * 200 + 300);
    cfg_write(ppa_pkg::REG_NUM_CATEGORIES, k);
    cfg_write(ppa_pkg::REG_NUM_SAMPLES, t);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, all and no responders, zero sums and log saturation
  task automatic test_directed_cases();
    configure(2, 1);
    send_element('1, '1, '1, '1, 1'b1);          // largest values, both respond
    send_element('1, '1, '1, '1, 1'b1);
    send_element('1, '1, '1, '1, 1'b0);          // no responders
    send_element(32'd1, 32'd7, 16'd0, 16'd0, 1'b0);
    send_element('0, '0, '0, '0, 1'b1);          // zero unstimulated and stimulated sums
    send_element('0, '0, '0, '0, 1'b1);
    configure(3, 1);
    // zero pu with nonzero ps pushes the log ratio past its top
    send_element('0, 32'h0001_0000, '0, 16'd5, 1'b1);
    send_element(32'h0002_0000, '0, 16'd3, '0, 1'b1);
    send_element(32'h0001_0000, 32'h1234, 16'd1, 16'd9, 1'b0);
    // responder with zero stimulated alpha gives ps of zero
    send_element(32'h8000_0000, '0, 16'hFFFF, '0, 1'b1);
    send_element(32'h0000_0001, 32'h10, '0, '0, 1'b1);
    send_element(32'h4000_0000, '1, 16'h1, 16'hFFFF, 1'b0);
  endtask

  // out-of-range and extreme register values
  task automatic test_register_extremes();
    configure(0, 0);                             // k below range, t of zero
    repeat (4) send_random_element();
    configure(1, 2);
    repeat (4) send_random_element();
    configure(127, 65535);                       // top t is written, then replaced
    configure(127, 1);                           // k above range acts as the maximum
    repeat (64) send_random_element();
    configure(64, 1);
    repeat (64) send_random_element();
  endtask

  // a write in the middle of a sample drops the partial sample
  task automatic test_restart_on_write();
    configure(5, 2);
    repeat (7) send_random_element();
    configure(5, 2);
    repeat (10) send_random_element();
  endtask

  // random runs, mostly small k, with occasional full drains and partial samples
  task automatic test_random_runs();
    int unsigned k, t, kk, tt, runs;
    while (words_sent < ITEMS) begin
      case ($urandom_range(0, 11))
        0: k = $urandom_range(65, 127);
        1: k = 64;
        2: k = $urandom_range(0, 1);
        default: k = $urandom_range(2, 8);
      endcase
      kk = (k < 2) ? 2 : (k > 64) ? 64 : k;
      t = (kk > 16) ? $urandom_range(0, 1) : $urandom_range(0, 4);
      tt = (t == 0) ? 1 : t;
      runs = $urandom_range(1, 2);
      configure(k, t);
      for (int n = 0; n < kk * tt * runs; n++) begin
        if (n % kk == 0 && $urandom_range(0, 19) == 0) drain(0);
        send_random_element();
      end
      if ($urandom_range(0, 5) == 0) begin
        // broken tail: a partial sample left for the next write to discard
        repeat ($urandom_range(1, kk - 1)) send_random_element();
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_word_if.valid  <= 1'b0;
    in_word_if.alpha_u_sample <= '0;
    in_word_if.alpha_s_sample <= '0;
    in_word_if.count_u        <= '0;
    in_word_if.count_s        <= '0;
    in_word_if.response_bit   <= 1'b0;
    for (int j = 0; j < MAXK; j++) begin
      au_mem[j] = 0; as_mem[j] = 0; resp_mem[j] = 0;
    end
    k_reg = 2;
    t_reg = 1;
    clear_run();
    errors = 0; words_sent = 0; means_seen = 0; cfg_writes = 0; burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_restart_on_write();
    test_random_runs();

    drain(64 * 200 + 500);
    $display("covered %0d elements, %0d category means, %0d register writes",
             words_sent, means_seen, cfg_writes);
    $display("k from below 2 to above 64, t from 0 upward, zero sums and log limits");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/ppa_pkg.sv
src/ppa_if.sv
src/ppa_ram.sv
src/ppa_div.sv
src/ppa_log2.sv
src/ppa_datapath.sv
src/ppa_ctrl.sv
src/posterior_proportion_averager.sv
src/ppa_checker.sv
sim/posterior_proportion_averager_tb.sv
